### rtl/feeder_jam_clear_sequencer_defines.svh
// assertion helpers for the feeder jam clear sequencer
// each macro expects clk and rst_n in scope
`ifndef FEEDER_JAM_CLEAR_SEQUENCER_DEFINES_SVH
`define FEEDER_JAM_CLEAR_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FJCS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication
`define FJCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define FJCS_ASSERT_IMPL(label, ante, cons)
`define FJCS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/fjcs_pkg.sv
`default_nettype none

package fjcs_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FEED_TICK_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEED_SPEED      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_LIMIT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_SPEED   = 3'd4;

  // register reset values
  localparam logic        [15:0] RST_FEED_TICK_LIMIT = 16'd500;
  localparam logic signed [15:0] RST_FEED_SPEED      = 16'sd2000;
  localparam logic        [7:0]  RST_JAM_LIMIT       = 8'd5;
  localparam logic signed [31:0] RST_REVERSE_OFFSET  = -32'sd8192;
  localparam logic signed [15:0] RST_REVERSE_SPEED   = -16'sd2000;

  typedef enum logic [1:0] {
    PH_SLEEP  = 2'd0,
    PH_RELOAD = 2'd1,
    PH_REVERT = 2'd2
  } phase_t;

  typedef struct packed {
    logic        [15:0] feed_tick_limit;
    logic signed [15:0] feed_speed;
    logic        [7:0]  jam_limit;
    logic signed [31:0] reverse_offset;
    logic signed [15:0] reverse_speed;
  } cfg_t;

  typedef struct packed {
    phase_t             mode;
    logic        [15:0] feed_ticks;
    logic        [7:0]  jam_count;
    logic signed [31:0] reverse_target;
    logic signed [15:0] held_speed;
  } state_t;

  typedef struct packed {
    logic signed [15:0] speed_command;
    logic               done_res;
    logic        [1:0]  phase;
  } result_t;

endpackage

`default_nettype wire

### rtl/fjcs_if.sv
`default_nettype none

// tick channel: motor position and stall flag
interface fjcs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] motor_position;
  logic               stalled;

  modport source (output valid, motor_position, stalled, input ready);
  modport sink   (input valid, motor_position, stalled, output ready);
endinterface

// result channel: speed command, done pulse and phase
interface fjcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_command;
  logic               done_res;
  logic        [1:0]  phase;

  modport source (output valid, speed_command, done_res, phase, input ready);
  modport sink   (input valid, speed_command, done_res, phase, output ready);
endinterface

`default_nettype wire

### rtl/feeder_jam_clear_sequencer.sv
// feeder jam clear sequencer
//
// in_ch carries one control tick per beat: motor position and stall flag.
// out_ch returns one beat per tick: held speed command, a done pulse on the
// tick the reload sequence finishes, and the phase after that tick.
// cfg_we / cfg_index / cfg_data write one of the five tuning registers;
// write them only while no tick is in flight.
//
// path: an accepted tick is held in the input register, then moves into the
// result register, which drives out_ch
// throughput: one tick per cycle while out_ch.ready is high; the phase,
// counters and target are updated by a single combinational step between the
// input register and the result register, so nothing iterates
// stall: while out_ch.ready is low the result holds and one more tick can sit
// in the input register; in_ch.ready drops only when both stages are full
// reset (rst_n low, synchronous): phase sleep, counters, target and held
// speed zero, registers at their defaults, both stages empty
`default_nettype none

`include "feeder_jam_clear_sequencer_defines.svh"

module feeder_jam_clear_sequencer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  fjcs_in_if.sink                              in_ch,
  fjcs_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [fjcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fjcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fjcs_pkg::*;

  // tuning registers
  cfg_t     cfg_r, cfg_nxt;

  // sequencer state, updated when a tick moves into the result register
  state_t   state_r;
  state_t   state_nxt;
  result_t  res_step;

  // input stage
  logic               in_valid_r, in_valid_nxt;
  logic signed [31:0] in_pos_r;
  logic               in_stalled_r;

  // result stage
  logic     out_valid_r, out_valid_nxt;
  result_t  out_res_r;

  logic     in_fire;
  logic     advance;

  // a waiting tick moves on: the result register is free or being drained this cycle
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  fjcs_step u_step (
    .state          (state_r),
    .cfg            (cfg_r),
    .motor_position (in_pos_r),
    .stalled        (in_stalled_r),
    .state_nxt      (state_nxt),
    .res            (res_step)
  );

  // register writes, upper bits of cfg_data dropped for narrow registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FEED_TICK_LIMIT: cfg_nxt.feed_tick_limit = cfg_data[15:0];
        CFG_FEED_SPEED:      cfg_nxt.feed_speed      = cfg_data[15:0];
        CFG_JAM_LIMIT:       cfg_nxt.jam_limit       = cfg_data[7:0];
        CFG_REVERSE_OFFSET:  cfg_nxt.reverse_offset  = cfg_data[31:0];
        CFG_REVERSE_SPEED:   cfg_nxt.reverse_speed   = cfg_data[15:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.feed_tick_limit <= RST_FEED_TICK_LIMIT;
      cfg_r.feed_speed      <= RST_FEED_SPEED;
      cfg_r.jam_limit       <= RST_JAM_LIMIT;
      cfg_r.reverse_offset  <= RST_REVERSE_OFFSET;
      cfg_r.reverse_speed   <= RST_REVERSE_SPEED;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stage occupancy
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{mode: PH_SLEEP, default: '0};
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_pos_r     <= in_ch.motor_position;
      in_stalled_r <= in_ch.stalled;
    end
    if (advance) begin
      out_res_r <= res_step;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.speed_command = out_res_r.speed_command;
  assign out_ch.done_res      = out_res_r.done_res;
  assign out_ch.phase         = out_res_r.phase;

  // a finishing beat always reports sleep with the speed cleared
  `FJCS_ASSERT_IMPL(a_done_is_sleep, out_valid_r && out_res_r.done_res,
    (out_res_r.phase == PH_SLEEP) && (out_res_r.speed_command == 16'sd0))
  // a stalled result must not let the state move on
  `FJCS_ASSERT_NEXT(a_state_holds, out_valid_r && !out_ch.ready, $stable(state_r))
  // a waiting tick is kept while the result is blocked
  `FJCS_ASSERT_NEXT(a_tick_kept, in_valid_r && out_valid_r && !out_ch.ready, in_valid_r)
  // sleep is only reached through reset or a finish, both of which clear both counters
  `FJCS_ASSERT_IMPL(a_sleep_cleared, state_r.mode == PH_SLEEP,
    (state_r.feed_ticks == 16'd0) && (state_r.jam_count == 8'd0))
  // revert is only entered after counting a jam
  `FJCS_ASSERT_IMPL(a_revert_has_jam, state_r.mode == PH_REVERT, state_r.jam_count != 8'd0)

endmodule

`default_nettype wire

### rtl/fjcs_step.sv
`default_nettype none

module fjcs_step (
  input  fjcs_pkg::state_t    state,
  input  fjcs_pkg::cfg_t      cfg,
  input  logic signed [31:0]  motor_position,
  input  logic                stalled,
  output fjcs_pkg::state_t    state_nxt,
  output fjcs_pkg::result_t   res
);
  import fjcs_pkg::*;

  logic [7:0] jam_inc;
  logic       feed_done;
  logic       jam_done;
  logic       finish;
  logic       back_out;
  phase_t     mode_nxt;

  assign jam_inc   = state.jam_count + 8'd1;
  assign feed_done = !stalled && (state.feed_ticks >= cfg.feed_tick_limit);
  assign jam_done  = stalled && !(jam_inc < cfg.jam_limit);
  assign finish    = (state.mode == PH_RELOAD) && (feed_done || jam_done);
  // revert ends on a stall or once the position reaches the target
  assign back_out  = stalled || ($signed(motor_position) <= $signed(state.reverse_target));

  // next phase
  always_comb begin
    mode_nxt = state.mode;
    case (state.mode)
      PH_SLEEP: begin
        mode_nxt = PH_RELOAD;
      end
      PH_RELOAD: begin
        if (finish) begin
          mode_nxt = PH_SLEEP;
        end else if (stalled) begin
          mode_nxt = PH_REVERT;
        end
      end
      PH_REVERT: begin
        if (back_out) begin
          mode_nxt = PH_RELOAD;
        end
      end
      default: begin
        mode_nxt = state.mode;
      end
    endcase
  end

  // counters, target and held speed
  always_comb begin
    state_nxt      = state;
    state_nxt.mode = mode_nxt;
    case (state.mode)
      PH_RELOAD: begin
        if (finish) begin
          state_nxt.feed_ticks = '0;
          state_nxt.jam_count  = '0;
          state_nxt.held_speed = '0;
        end else if (!stalled) begin
          state_nxt.held_speed = cfg.feed_speed;
          state_nxt.feed_ticks = state.feed_ticks + 16'd1;
        end else begin
          state_nxt.jam_count      = jam_inc;
          state_nxt.reverse_target = motor_position + cfg.reverse_offset;
        end
      end
      PH_REVERT: begin
        if (!back_out) begin
          state_nxt.held_speed = cfg.reverse_speed;
        end
      end
      default: begin
        state_nxt.held_speed = state.held_speed;
      end
    endcase
  end

  assign res.speed_command = state_nxt.held_speed;
  assign res.done_res      = finish;
  assign res.phase         = state_nxt.mode;

endmodule

`default_nettype wire
